### sv/vlap_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and sizing helpers of the seven-point laplacian
package vlap_pkg;

  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;
  localparam int unsigned DefMaxDepth  = 256;

  localparam int unsigned WidthRegW  = 7;
  localparam int unsigned HeightRegW = 7;
  localparam int unsigned DepthRegW  = 9;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned LaplaceW = 20;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam int unsigned QueueDepth = 4;

  // flag bits carried by every queue entry besides sample and addresses
  localparam int unsigned EntryFlagW = 9;

  typedef enum logic [ApbAddrW-1:0] {
    RegWidth  = 4'h0,
    RegHeight = 4'h4,
    RegDepth  = 4'h8
  } reg_addr_e;

  typedef enum logic {
    ActSample = 1'b0,
    ActFlush  = 1'b1
  } action_e;

  typedef struct packed {
    action_e                    action;
    logic signed [SampleW-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic signed [LaplaceW-1:0] laplace_value;
    logic                       last_voxel;
  } out_item_t;

  // ring of two planes plus one voxel
  function automatic int unsigned ring_depth(int unsigned mw, int unsigned mh);
    return 2 * mw * mh + 1;
  endfunction

  function automatic int unsigned ring_aw(int unsigned mw, int unsigned mh);
    return $clog2(2 * mw * mh + 1);
  endfunction

  function automatic int unsigned entry_w(int unsigned aw);
    return EntryFlagW + SampleW + 7 * aw;
  endfunction

endpackage

### sv/vlap_queue.sv
`timescale 1ns / 1ps
// small register fifo between the front and back parts
module vlap_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### sv/vlap_front.sv
`timescale 1ns / 1ps
// front part: size registers, item classification, counters and ring addressing
module vlap_front
  import vlap_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned MAX_DEPTH  = DefMaxDepth,
  localparam int unsigned AW        = ring_aw(MAX_WIDTH, MAX_HEIGHT),
  localparam int unsigned EntryW    = entry_w(AW)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_i,
  input  logic [ApbAddrW-1:0] cfg_addr_i,
  input  logic [ApbDataW-1:0] cfg_wdata_i,
  output logic [ApbDataW-1:0] cfg_rdata_o,
  input  in_item_t            in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [EntryW-1:0]   q_data_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam longint unsigned PlaneMax = longint'(MAX_WIDTH) * MAX_HEIGHT;
  localparam longint unsigned TotalMax = PlaneMax * MAX_DEPTH;
  localparam int unsigned PW = $clog2(PlaneMax + 1);
  localparam int unsigned CW = $clog2(TotalMax + 1);
  localparam logic [AW:0] RingSize = (AW + 1)'(ring_depth(MAX_WIDTH, MAX_HEIGHT));

  typedef struct packed {
    logic                      wr;
    logic                      emit;
    logic                      last;
    logic                      x_lo;
    logic                      x_hi;
    logic                      y_lo;
    logic                      y_hi;
    logic                      z_lo;
    logic                      z_hi;
    logic signed [SampleW-1:0] sample;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             a_c;
    logic [AW-1:0]             a_xp;
    logic [AW-1:0]             a_xm;
    logic [AW-1:0]             a_yp;
    logic [AW-1:0]             a_ym;
    logic [AW-1:0]             a_zm;
  } entry_t;

  logic [WidthRegW-1:0]  w_raw_q;
  logic [HeightRegW-1:0] h_raw_q;
  logic [DepthRegW-1:0]  d_raw_q;
  logic [1:0]            settle_q;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [DW-1:0]         d_eff;
  logic [WW+HW-1:0]      plane_prod;
  logic [PW+DW-1:0]      total_prod;
  logic [PW-1:0]         plane_q;
  logic [CW-1:0]         total_q;
  logic [CW-1:0]         st_q, rg_q;
  logic [AW-1:0]         wp_q, rp_q;
  logic [WW-1:0]         x_q, x_d;
  logic [HW-1:0]         y_q, y_d;
  logic [DW-1:0]         z_q, z_d;
  logic                  accept, take, emit, is_sample;
  logic [CW:0]           emit_mark;
  entry_t                ent;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] p, logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= RingSize) begin
      s = s - RingSize;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_sub(logic [AW-1:0] p, logic [AW-1:0] k);
    logic [AW:0] s;
    if (p >= k) begin
      s = {1'b0, p} - {1'b0, k};
    end else begin
      s = {1'b0, p} + RingSize - {1'b0, k};
    end
    return s[AW-1:0];
  endfunction

  // out of range sizes act as one or as the maximum
  always_comb begin
    if (w_raw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(w_raw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_raw_q);
    end
    if (h_raw_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(h_raw_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_raw_q);
    end
    if (d_raw_q == '0) begin
      d_eff = DW'(1);
    end else if (32'(d_raw_q) > MAX_DEPTH) begin
      d_eff = DW'(MAX_DEPTH);
    end else begin
      d_eff = DW'(d_raw_q);
    end
  end

  assign plane_prod = (WW + HW)'(w_eff) * (WW + HW)'(h_eff);
  assign total_prod = (PW + DW)'(plane_q) * (PW + DW)'(d_eff);

  always_ff @(posedge clk_i) begin
    plane_q <= PW'(plane_prod);
    total_q <= CW'(total_prod);
  end

  always_comb begin
    case (reg_addr_e'(cfg_addr_i))
      RegWidth:  cfg_rdata_o = ApbDataW'(w_raw_q);
      RegHeight: cfg_rdata_o = ApbDataW'(h_raw_q);
      RegDepth:  cfg_rdata_o = ApbDataW'(d_raw_q);
      default:   cfg_rdata_o = '0;
    endcase
  end

  // classification of the offered item
  assign in_ready_o = !q_full_i && (settle_q == '0);
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (in_i.action == ActSample);
  assign take       = is_sample && (st_q < total_q);
  assign emit_mark  = {1'b0, rg_q} + (CW + 1)'(plane_q);
  // a sample releases the voxel one plane behind it
  assign emit = (rg_q < total_q) &&
                ((take && ({1'b0, st_q} >= emit_mark)) ||
                 (!is_sample && (st_q == total_q)));
  assign q_push_o = accept && (take || emit);

  always_comb begin
    ent.wr     = take;
    ent.emit   = emit;
    ent.last   = ((rg_q + CW'(1)) == total_q);
    ent.x_lo   = (x_q == '0);
    ent.x_hi   = ((x_q + WW'(1)) == w_eff);
    ent.y_lo   = (y_q == '0);
    ent.y_hi   = ((y_q + HW'(1)) == h_eff);
    ent.z_lo   = (z_q == '0);
    ent.z_hi   = ((z_q + DW'(1)) == d_eff);
    ent.sample = in_i.sample;
    ent.waddr  = wp_q;
    ent.a_c    = rp_q;
    ent.a_xp   = ring_add(rp_q, AW'(1));
    ent.a_xm   = ring_sub(rp_q, AW'(1));
    ent.a_yp   = ring_add(rp_q, AW'(w_eff));
    ent.a_ym   = ring_sub(rp_q, AW'(w_eff));
    ent.a_zm   = ring_sub(rp_q, AW'(plane_q));
  end

  assign q_data_o = ent;

  always_comb begin
    x_d = x_q + WW'(1);
    y_d = y_q;
    z_d = z_q;
    if ((x_q + WW'(1)) == w_eff) begin
      x_d = '0;
      y_d = y_q + HW'(1);
      if ((y_q + HW'(1)) == h_eff) begin
        y_d = '0;
        z_d = z_q + DW'(1);
        if ((z_q + DW'(1)) == d_eff) begin
          z_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_raw_q  <= WidthRegW'(DefMaxWidth);
      h_raw_q  <= HeightRegW'(DefMaxHeight);
      d_raw_q  <= DepthRegW'(DefMaxDepth);
      settle_q <= 2'd2;
      st_q     <= '0;
      rg_q     <= '0;
      wp_q     <= '0;
      rp_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
    end else begin
      if (settle_q != '0) begin
        settle_q <= settle_q - 2'd1;
      end
      if (accept && take) begin
        st_q <= st_q + CW'(1);
        wp_q <= ring_add(wp_q, AW'(1));
      end
      if (accept && emit) begin
        rg_q <= rg_q + CW'(1);
        rp_q <= ring_add(rp_q, AW'(1));
        x_q  <= x_d;
        y_q  <= y_d;
        z_q  <= z_d;
      end
      // a size write restarts the volume; plane is re-registered, then total from it
      if (cfg_wr_i && ((cfg_addr_i == RegWidth) || (cfg_addr_i == RegHeight) ||
                       (cfg_addr_i == RegDepth))) begin
        case (reg_addr_e'(cfg_addr_i))
          RegWidth:  w_raw_q <= cfg_wdata_i[WidthRegW-1:0];
          RegHeight: h_raw_q <= cfg_wdata_i[HeightRegW-1:0];
          RegDepth:  d_raw_q <= cfg_wdata_i[DepthRegW-1:0];
          default:   ;
        endcase
        settle_q <= 2'd2;
        st_q     <= '0;
        rg_q     <= '0;
        wp_q     <= '0;
        rp_q     <= '0;
        x_q      <= '0;
        y_q      <= '0;
        z_q      <= '0;
      end
    end
  end

endmodule

### sv/vlap_back.sv
`timescale 1ns / 1ps
// back part: voxel ring memories, neighbor reads and the stencil sum
module vlap_back
  import vlap_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  localparam int unsigned AW        = ring_aw(MAX_WIDTH, MAX_HEIGHT),
  localparam int unsigned EntryW    = entry_w(AW)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [EntryW-1:0] q_data_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output out_item_t         out_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  localparam int unsigned RingDepth = ring_depth(MAX_WIDTH, MAX_HEIGHT);

  typedef struct packed {
    logic                      wr;
    logic                      emit;
    logic                      last;
    logic                      x_lo;
    logic                      x_hi;
    logic                      y_lo;
    logic                      y_hi;
    logic                      z_lo;
    logic                      z_hi;
    logic signed [SampleW-1:0] sample;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             a_c;
    logic [AW-1:0]             a_xp;
    logic [AW-1:0]             a_xm;
    logic [AW-1:0]             a_yp;
    logic [AW-1:0]             a_ym;
    logic [AW-1:0]             a_zm;
  } entry_t;

  typedef struct packed {
    logic                      last;
    logic                      x_lo;
    logic                      x_hi;
    logic                      y_lo;
    logic                      y_hi;
    logic                      z_lo;
    logic                      z_hi;
    logic signed [SampleW-1:0] sample;
  } stencil_ctl_t;

  // three copies of the ring, two read ports each
  logic [SampleW-1:0] mem_a [RingDepth];
  logic [SampleW-1:0] mem_b [RingDepth];
  logic [SampleW-1:0] mem_c [RingDepth];

  entry_t                     head;
  stencil_ctl_t               s1_ctl_q;
  logic                       s1_v_q, out_v_q, s1_go, pop;
  logic signed [SampleW-1:0]  rd_c_q, rd_xp_q, rd_xm_q, rd_yp_q, rd_ym_q, rd_zm_q;
  logic signed [LaplaceW-1:0] c, xp, xm, yp, ym, zp, zm, sum;
  out_item_t                  out_q;

  assign head    = entry_t'(q_data_i);
  assign s1_go   = s1_v_q && (!out_v_q || out_ready_i);
  // entries that only store a sample never wait for the stencil stage
  assign pop     = !q_empty_i && (!head.emit || !s1_v_q || s1_go);
  assign q_pop_o = pop;

  always_ff @(posedge clk_i) begin
    if (pop && head.wr) begin
      mem_a[head.waddr] <= head.sample;
      mem_b[head.waddr] <= head.sample;
      mem_c[head.waddr] <= head.sample;
    end
    if (pop && head.emit) begin
      rd_c_q   <= mem_a[head.a_c];
      rd_xp_q  <= mem_a[head.a_xp];
      rd_xm_q  <= mem_b[head.a_xm];
      rd_yp_q  <= mem_b[head.a_yp];
      rd_ym_q  <= mem_c[head.a_ym];
      rd_zm_q  <= mem_c[head.a_zm];
      s1_ctl_q <= '{last: head.last, x_lo: head.x_lo, x_hi: head.x_hi,
                    y_lo: head.y_lo, y_hi: head.y_hi, z_lo: head.z_lo,
                    z_hi: head.z_hi, sample: head.sample};
    end
  end

  // clamped neighbors fall back to the center voxel
  always_comb begin
    c   = LaplaceW'(rd_c_q);
    xp  = s1_ctl_q.x_hi ? c : LaplaceW'(rd_xp_q);
    xm  = s1_ctl_q.x_lo ? c : LaplaceW'(rd_xm_q);
    yp  = s1_ctl_q.y_hi ? c : LaplaceW'(rd_yp_q);
    ym  = s1_ctl_q.y_lo ? c : LaplaceW'(rd_ym_q);
    zp  = s1_ctl_q.z_hi ? c : LaplaceW'(s1_ctl_q.sample);
    zm  = s1_ctl_q.z_lo ? c : LaplaceW'(rd_zm_q);
    sum = xp + xm + yp + ym + zp + zm - (c <<< 2) - (c <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.laplace_value <= sum;
      out_q.last_voxel    <= s1_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop && head.emit) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_v_q;

endmodule

### sv/volume_laplacian_7pt.sv
`timescale 1ns / 1ps
// top level of the streaming seven-point 3d laplacian
// Voxels enter in x-fastest raster order, one item per clock while ready, and the
// result for a voxel leaves when the voxel one plane further on is taken, or on
// flush items once the whole volume is in; the last result carries last_voxel. One
// item per cycle is sustained end to end while the output is ready: the front
// classifies and counts each item, a four-entry queue decouples it from the back,
// and the back stores each sample into three copies of a ring of 2*MAX_WIDTH*
// MAX_HEIGHT+1 voxels (two read ports each), reading the center and five neighbors
// together; +z is the releasing item's sample. The releasing entry passes the queue,
// then the ring read registers, then the stencil sum's output register. After reset
// and after every size register write the input stays not ready while plane and
// volume sizes are recomputed; each size write also restarts the volume.
module volume_laplacian_7pt
  import vlap_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned MAX_DEPTH  = DefMaxDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output out_item_t           out_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AW     = ring_aw(MAX_WIDTH, MAX_HEIGHT);
  localparam int unsigned EntryW = entry_w(AW);

  logic              cfg_wr;
  logic              q_push, q_pop, q_full, q_empty;
  logic [EntryW-1:0] q_in, q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  vlap_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .cfg_addr_i  (paddr),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (prdata),
    .in_i        (in_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  vlap_queue #(
    .WIDTH (EntryW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  vlap_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the streaming seven-point 3d laplacian
module testbench;
  import vlap_pkg::*;

  localparam int unsigned StoreSize = 2 * DefMaxWidth * DefMaxHeight + 1;
  localparam int unsigned IdleLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  in_item_t in_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  out_item_t out_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  always #1 clk_i = ~clk_i;

  volume_laplacian_7pt u_dut (.*);

  // predictor state
  logic [15:0] voxel_ring [StoreSize];
  int unsigned cfg_w = 64, cfg_h = 64, cfg_d = 256;
  int unsigned taken = 0, given = 0, px = 0, py = 0, pz = 0;
  out_item_t laplace_q [$];
  int errors = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_recv = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned eff_size(int unsigned v, int unsigned m);
    return (v < 1) ? 1 : ((v > m) ? m : v);
  endfunction

  function automatic int signed voxel_at(int signed x, int signed y, int signed z,
                                         int unsigned w, int unsigned h, int unsigned d);
    longint unsigned lin;
    x = (x < 0) ? 0 : ((x > int'(w) - 1) ? int'(w) - 1 : x);
    y = (y < 0) ? 0 : ((y > int'(h) - 1) ? int'(h) - 1 : y);
    z = (z < 0) ? 0 : ((z > int'(d) - 1) ? int'(d) - 1 : z);
    lin = longint'(z) * w * h + longint'(y) * w + x;
    return int'($signed(voxel_ring[lin % StoreSize]));
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_laplace(in_item_t it);
    int unsigned w, h, d, plane, total;
    bit fire;
    int signed x, y, z, sum;
    out_item_t r;
    w = eff_size(cfg_w, DefMaxWidth);
    h = eff_size(cfg_h, DefMaxHeight);
    d = eff_size(cfg_d, DefMaxDepth);
    plane = w * h;
    total = plane * d;
    fire = 0;
    if (it.action == ActSample) begin
      if (taken >= total) return;
      voxel_ring[taken % StoreSize] = it.sample;
      taken++;
      fire = (given < total) && (taken >= given + plane + 1);
    end else begin
      fire = (taken == total) && (given < total);
    end
    if (!fire) return;
    x = px; y = py; z = pz;
    sum = voxel_at(x+1, y, z, w, h, d) + voxel_at(x-1, y, z, w, h, d)
        + voxel_at(x, y+1, z, w, h, d) + voxel_at(x, y-1, z, w, h, d)
        + voxel_at(x, y, z+1, w, h, d) + voxel_at(x, y, z-1, w, h, d)
        - 6 * voxel_at(x, y, z, w, h, d);
    given++;
    r.laplace_value = sum[LaplaceW-1:0];
    r.last_voxel = (given == total);
    laplace_q.push_back(r);
    px++;
    if (px >= w) begin
      px = 0; py++;
      if (py >= h) begin
        py = 0; pz++;
        if (pz >= d) pz = 0;
      end
    end
  endtask

  // predict and check on the same edge the handshakes happen
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_laplace(in_i);
      if (out_valid_o && out_ready_i) begin
        if (laplace_q.size() == 0) begin
          $error("result with nothing expected: laplace_value %0d", out_o.laplace_value);
          errors++;
        end else begin
          e = laplace_q.pop_front();
          if (out_o.laplace_value !== e.laplace_value) begin
            $error("laplace_value expected %0d got %0d", e.laplace_value,
                   out_o.laplace_value);
            errors++;
          end
          if (out_o.last_voxel !== e.last_voxel) begin
            $error("last_voxel expected %0b got %0b", e.last_voxel, out_o.last_voxel);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high after the accepting edge until the next item or an idle cycle
  task automatic send_item(logic act, logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_i <= '{action: action_e'(act), sample: smp};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (laplace_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_addr_e a, int unsigned v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (a)
      RegWidth: cfg_w = v & 'h7f;
      RegHeight: cfg_h = v & 'h7f;
      default: cfg_d = v & 'h1ff;
    endcase
    taken = 0; given = 0; px = 0; py = 0; pz = 0;
    @(posedge clk_i);
  endtask

  task automatic set_volume(int unsigned w, int unsigned h, int unsigned d);
    drain();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegDepth, d);
  endtask

  // whole volume plus a few extra samples and flushes, returns items sent
  task automatic run_volume(int unsigned n, int mode, inout int sent);
    int unsigned k;
    int unsigned plane;
    logic [15:0] s;
    plane = eff_size(cfg_w, DefMaxWidth) * eff_size(cfg_h, DefMaxHeight);
    for (k = 0; k < n; k++) begin
      case (mode)
        0: s = $urandom;
        1: s = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: s = $urandom_range(3) == 0 ? 16'h8000 : 16'h7fff;
      endcase
      if ($urandom_range(30) == 0) send_item(ActFlush, $urandom);  // early flush
      send_item(ActSample, s);
      sent++;
    end
    repeat ($urandom_range(2)) send_item(ActSample, $urandom);     // extra samples
    for (k = 0; k < plane + 2; k++) begin
      send_item(ActFlush, $urandom);
      sent++;
      if (given == taken) break;
    end
    send_item(ActFlush, $urandom);
  endtask

  typedef struct {
    logic act;
    logic [15:0] smp;
    logic [19:0] val;
    bit typed;
  } directed_row_t;

  // 1x1x1 volume: every neighbor clamps to the center, result is always zero
  directed_row_t directed_rows [] = '{
    '{ActFlush, 16'h0000, 20'h0, 1'b0},
    '{ActSample, 16'h7fff, 20'h0, 1'b0},
    '{ActSample, 16'h1234, 20'h0, 1'b0},
    '{ActFlush, 16'hffff, 20'h0, 1'b1}
  };

  initial begin
    int sent;
    int unsigned w, h, d, i, ph;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    write_reg(RegWidth, 1); write_reg(RegHeight, 1); write_reg(RegDepth, 1);
    foreach (directed_rows[j]) begin
      send_item(directed_rows[j].act, directed_rows[j].smp);
      if (directed_rows[j].typed) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        if (laplace_q.size() == 0) begin
          $error("laplace_value expected %0d got no result", directed_rows[j].val);
          errors++;
        end else if (laplace_q[$].laplace_value !== directed_rows[j].val) begin
          $error("laplace_value expected %0d got %0d", directed_rows[j].val,
                 laplace_q[$].laplace_value);
          errors++;
        end
        @(posedge clk_i);
      end
    end
    // zero sizes act as one, oversize clamps
    set_volume(0, 0, 0);
    run_volume(1, 1, sent);
    set_volume(2, 2, 2);
    run_volume(8, 1, sent);
    set_volume(3, 2, 3);
    run_volume(18, 2, sent);
    set_volume(127, 1, 1);
    run_volume(64, 0, sent);
    set_volume(1, 127, 1);
    run_volume(64, 0, sent);

    ph = 0;
    while (sent < 1200) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_idle_pct = 0; end
        1: begin send_idle_pct = 71; recv_idle_pct = 0; end
        2: begin send_idle_pct = 0; recv_idle_pct = 71; end
        default: begin send_idle_pct = 36; recv_idle_pct = 36; end
      endcase
      w = $urandom_range(1, 6); h = $urandom_range(1, 6); d = $urandom_range(1, 5);
      if (ph == 3) d = 511;
      set_volume(w, h, d);
      if (ph == 2) begin
        // receiver holds off while the sender keeps pushing
        fork
          begin hold_recv = 1; repeat (300) @(posedge clk_i); hold_recv = 0; end
        join_none
      end
      run_volume(eff_size(w, 64) * eff_size(h, 64) *
                 (ph == 3 ? 256 / 64 * 0 + eff_size(d, 5) : d), 0, sent);
      if (ph == 5) drain();
      ph++;
    end
    set_volume(127, 3, 2);
    run_volume(384, 0, sent);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
